// File: sv/mpw_pkg.sv
package mpw_pkg;

    // Item field widths
    localparam int CHAN_W   = 3;
    localparam int CAP_W    = 14;
    localparam int WRAP_W   = 8;
    localparam int WIDTH_W  = 32;
    localparam int FLAGS_W  = 8;
    localparam int MULT_W   = 24;

    // Window registers
    localparam int WIN_W      = 22;
    localparam int REG_COUNT  = 8;
    localparam int WIN_COUNT  = REG_COUNT / 2;
    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Item codes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_EDGE    = 1'b1;
    localparam logic LEVEL_RISE = 1'b1;
    localparam logic LEVEL_FALL = 1'b0;

    // Window bounds, index 0 first: low/high pairs a, b, c, d
    typedef logic [0:REG_COUNT-1][WIN_W-1:0] win_regs_t;

    localparam win_regs_t WIN_RESET = '{
        22'd300,  22'd800,
        22'd1400, 22'd1800,
        22'd4200, 22'd4700,
        22'd2000, 22'd2600
    };

    // Per-channel update strobes for one transaction
    typedef struct packed {
        logic tick;
        logic rise;
        logic fall;
        logic hit;
    } chan_ctl_t;

endpackage

// File: sv/mpw_in_if.sv
interface mpw_in_if import mpw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic              group;
    logic [CHAN_W-1:0] channel;
    logic              level;
    logic [CAP_W-1:0]  capture;

    modport source (output valid, opcode, group, channel, level, capture, input ready);
    modport sink   (input valid, opcode, group, channel, level, capture, output ready);
endinterface

// File: sv/mpw_out_if.sv
interface mpw_out_if import mpw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               measured;
    logic [CHAN_W-1:0]  out_channel;
    logic [WIDTH_W-1:0] pulse_width;
    logic               pulse_ok;
    logic [FLAGS_W-1:0] all_flags;

    modport source (output valid, measured, out_channel, pulse_width, pulse_ok, all_flags,
                    input ready);
    modport sink   (input valid, measured, out_channel, pulse_width, pulse_ok, all_flags,
                    output ready);
endinterface

// File: sv/multichannel_pulse_width_window_check.sv
// Pulse-width window checker for NUM_CHANNELS capture channels.
// Input channel (in_ch): one transaction per event. A tick (opcode 0) counts
// one counter wrap for every channel of the given timer group. An edge
// (opcode 1) carries channel, pin level and the captured counter value: a
// rising edge restarts the channel, a falling edge produces the width
// wraps*COUNTS_PER_WRAP + capture - start (mod 2^32) and a window verdict.
// Output channel (out_ch): exactly one transaction per input transaction, in
// order, with the updated flag vector of all channels.
// Window bounds are written over the APB port, 4 bytes per register, and
// should only change while no transaction is in flight.
// Input acceptance and output valid are separated by the input register,
// then the result register. Throughput: one transaction per cycle while
// out_ch.ready stays high; the per-channel state is read and written in
// the same stage, so back-to-back events on one channel need no forwarding.
// Stall: when out_ch.ready is low the result register holds, the input
// register keeps one more transaction, and then in_ch.ready drops.
// Reset: all channel state, flags and pipeline valids clear; window
// registers return to their defaults.
module multichannel_pulse_width_window_check import mpw_pkg::*; #(
    parameter int NUM_CHANNELS       = 8,
    parameter int CHANNELS_PER_GROUP = 4,
    parameter int COUNTS_PER_WRAP    = 10000
) (
    input  logic                  clk,
    input  logic                  rst_n,
    mpw_in_if.sink                in_ch,
    mpw_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [MULT_W-1:0] CPW = MULT_W'(COUNTS_PER_WRAP);

    win_regs_t win;

    // Input register
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_opcode_reg;
    logic              s1_group_reg;
    logic [CHAN_W-1:0] s1_channel_reg;
    logic              s1_level_reg;
    logic [CAP_W-1:0]  s1_capture_reg;

    // Result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               measured_reg;
    logic [CHAN_W-1:0]  out_channel_reg;
    logic [WIDTH_W-1:0] pulse_width_reg;
    logic               pulse_ok_reg;
    logic [FLAGS_W-1:0] all_flags_reg;

    logic in_take;
    logic advance;

    logic                    present;
    logic                    is_tick;
    logic                    is_rise;
    logic                    is_fall;
    logic [CAP_W-1:0]        sel_start;
    logic [WRAP_W-1:0]       sel_wrap;
    logic [MULT_W-1:0]       wrap_counts;
    logic [WIDTH_W-1:0]      width;
    logic                    hit;
    logic [FLAGS_W-1:0]      flags_comb;

    chan_ctl_t               ctl       [NUM_CHANNELS];
    logic [CAP_W-1:0]        start_q   [NUM_CHANNELS];
    logic [WRAP_W-1:0]       wrap_q    [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] flag_next;

    mpw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .win     (win)
    );

    // Handshake: stage 1 moves on when the result register is free or drains
    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    assign s1_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_opcode_reg  <= in_ch.opcode;
            s1_group_reg   <= in_ch.group;
            s1_channel_reg <= in_ch.channel;
            s1_level_reg   <= in_ch.level;
            s1_capture_reg <= in_ch.capture;
        end
    end

    // Decode
    assign present = 32'(s1_channel_reg) < NUM_CHANNELS;
    assign is_tick = advance && (s1_opcode_reg == OP_TICK);
    assign is_rise = (s1_opcode_reg == OP_EDGE) && present && (s1_level_reg == LEVEL_RISE);
    assign is_fall = (s1_opcode_reg == OP_EDGE) && present && (s1_level_reg == LEVEL_FALL);

    // Channel state select
    always_comb
    begin
        sel_start = '0;
        sel_wrap  = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (32'(s1_channel_reg) == i)
            begin
                sel_start = start_q[i];
                sel_wrap  = wrap_q[i];
            end
        end
    end

    // Width: one small constant multiply and an add/subtract
    assign wrap_counts = MULT_W'(sel_wrap) * CPW;
    assign width = WIDTH_W'(wrap_counts) + WIDTH_W'(s1_capture_reg) - WIDTH_W'(sel_start);

    mpw_win u_win (
        .pulse_width (width),
        .win         (win),
        .hit         (hit)
    );

    // Per-channel state
    for (genvar i = 0; i < NUM_CHANNELS; i++)
    begin : g_chan
        localparam int GRP = i / CHANNELS_PER_GROUP;
        logic sel;

        assign sel = (32'(s1_channel_reg) == i);

        assign ctl[i].tick = is_tick && (32'(s1_group_reg) == GRP);
        assign ctl[i].rise = advance && is_rise && sel;
        assign ctl[i].fall = advance && is_fall && sel;
        assign ctl[i].hit  = hit;

        mpw_chan u_chan (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl[i]),
            .capture   (s1_capture_reg),
            .start     (start_q[i]),
            .wraps     (wrap_q[i]),
            .flag_next (flag_next[i])
        );
    end

    // Flag vector shows the first eight channels only
    for (genvar b = 0; b < FLAGS_W; b++)
    begin : g_flags
        if (b < NUM_CHANNELS)
        begin : g_on
            assign flags_comb[b] = flag_next[b];
        end
        else
        begin : g_off
            assign flags_comb[b] = 1'b0;
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            measured_reg    <= is_fall;
            out_channel_reg <= (s1_opcode_reg == OP_EDGE) ? s1_channel_reg : '0;
            pulse_width_reg <= is_fall ? width : '0;
            pulse_ok_reg    <= is_fall && hit;
            all_flags_reg   <= flags_comb;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.measured    = measured_reg;
    assign out_ch.out_channel = out_channel_reg;
    assign out_ch.pulse_width = pulse_width_reg;
    assign out_ch.pulse_ok    = pulse_ok_reg;
    assign out_ch.all_flags   = all_flags_reg;

endmodule

// File: sv/mpw_cfg.sv
module mpw_cfg import mpw_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output win_regs_t             win
);

    win_regs_t            win_reg;
    win_regs_t            win_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register write decode
    always_comb
    begin
        win_next = win_reg;
        if (wr_en)
        begin
            win_next[reg_idx] = pwdata[WIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= WIN_RESET;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    // Readback
    assign prdata = {{(APB_DATA_W-WIN_W){1'b0}}, win_reg[reg_idx]};
    assign win    = win_reg;

endmodule

// File: sv/mpw_win.sv
module mpw_win import mpw_pkg::*; (
    input  logic [WIDTH_W-1:0] pulse_width,
    input  win_regs_t          win,
    output logic               hit
);

    logic [WIDTH_W-1:0] lo;
    logic [WIDTH_W-1:0] hi;

    // Strict compare against each of the windows
    always_comb
    begin
        hit = 1'b0;
        lo  = '0;
        hi  = '0;
        for (int k = 0; k < WIN_COUNT; k++)
        begin
            lo = {{(WIDTH_W-WIN_W){1'b0}}, win[2*k]};
            hi = {{(WIDTH_W-WIN_W){1'b0}}, win[2*k+1]};
            if ((pulse_width > lo) && (pulse_width < hi))
            begin
                hit = 1'b1;
            end
        end
    end

endmodule

// File: sv/mpw_chan.sv
module mpw_chan import mpw_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  chan_ctl_t         ctl,
    input  logic [CAP_W-1:0]  capture,
    output logic [CAP_W-1:0]  start,
    output logic [WRAP_W-1:0] wraps,
    output logic              flag_next
);

    logic [CAP_W-1:0]  start_reg;
    logic [CAP_W-1:0]  start_next;
    logic [WRAP_W-1:0] wrap_reg;
    logic [WRAP_W-1:0] wrap_next;
    logic              flag_reg;

    // Rising edge restarts the measurement, tick counts a counter wrap
    always_comb
    begin
        start_next = start_reg;
        wrap_next  = wrap_reg;
        if (ctl.rise)
        begin
            start_next = capture;
            wrap_next  = '0;
        end
        else if (ctl.tick)
        begin
            wrap_next = wrap_reg + WRAP_W'(1);
        end
    end

    assign flag_next = ctl.fall ? ctl.hit : flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            wrap_reg  <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            wrap_reg  <= wrap_next;
            flag_reg  <= flag_next;
        end
    end

    assign start = start_reg;
    assign wraps = wrap_reg;

endmodule

// File: tb/tb_multichannel_pulse_width_window_check.sv
`timescale 1ns / 1ps

import mpw_pkg::*;

// One event on the capture input
typedef struct packed {
    logic               op;
    logic               grp;
    logic [CHAN_W-1:0]  ch;
    logic               lvl;
    logic [CAP_W-1:0]   cap;
} capture_event_t;

// One measurement on the result output
typedef struct packed {
    logic               measured;
    logic [CHAN_W-1:0]  ch;
    logic [WIDTH_W-1:0] width;
    logic               ok;
    logic [FLAGS_W-1:0] flags;
} pulse_result_t;

typedef enum int {
    WIN_A_LOW, WIN_A_HIGH, WIN_B_LOW, WIN_B_HIGH,
    WIN_C_LOW, WIN_C_HIGH, WIN_D_LOW, WIN_D_HIGH
} win_reg_t;

typedef enum int {
    WS_RANDOM, WS_ZERO, WS_WIDE, WS_MAX, WS_INVERTED, WS_UPPER_NOISE, WS_DEFAULT
} window_setting_t;

typedef enum int { FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH } flow_mode_t;

// Tracks channel state, predicts each measurement and checks it in order
class pulse_window_scoreboard #(int NUM_CH = 8, int CH_PER_GRP = 4, int COUNTS_PER_WRAP = 10000);
    logic [WIN_W-1:0]   win_bounds [REG_COUNT];
    logic [CAP_W-1:0]   start_cap [NUM_CH];
    logic [WRAP_W-1:0]  wraps [NUM_CH];
    logic [FLAGS_W-1:0] flags;
    pulse_result_t      pending_results [$];
    int                 mismatches;
    int                 n_results;
    int                 n_measured;
    int                 n_hits;

    function new();
        for (int i = 0; i < REG_COUNT; i++)
            win_bounds[i] = WIN_RESET[i];
        for (int i = 0; i < NUM_CH; i++)
        begin
            start_cap[i] = '0;
            wraps[i]     = '0;
        end
        flags      = '0;
        mismatches = 0;
        n_results  = 0;
        n_measured = 0;
        n_hits     = 0;
    endfunction

    function void set_window(int idx, logic [WIN_W-1:0] value);
        win_bounds[idx] = value;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    // Exclusive at both ends; a window with low >= high matches nothing
    function bit inside_window(logic [WIDTH_W-1:0] w);
        for (int k = 0; k < REG_COUNT; k += 2)
            if (w > WIDTH_W'(win_bounds[k]) && w < WIDTH_W'(win_bounds[k+1]))
                return 1'b1;
        return 1'b0;
    endfunction

    // Accepted transaction: update channel state and queue the expected result
    function void note_event(capture_event_t it);
        pulse_result_t      r;
        logic [WIDTH_W-1:0] w;
        int                 first;
        r = '0;
        if (it.op == OP_TICK)
        begin
            first = int'(it.grp) * CH_PER_GRP;
            for (int k = 0; k < CH_PER_GRP; k++)
                if (first + k < NUM_CH)
                    wraps[first + k] = wraps[first + k] + WRAP_W'(1);
        end
        else
        begin
            r.ch = it.ch;
            if (int'(it.ch) < NUM_CH)
            begin
                if (it.lvl == LEVEL_RISE)
                begin
                    start_cap[it.ch] = it.cap;
                    wraps[it.ch]     = '0;
                end
                else
                begin
                    // wrap count is kept; only a rising edge clears it
                    w = WIDTH_W'(wraps[it.ch]) * WIDTH_W'(COUNTS_PER_WRAP);
                    w = w + WIDTH_W'(it.cap) - WIDTH_W'(start_cap[it.ch]);
                    flags[it.ch] = inside_window(w);
                    r.measured   = 1'b1;
                    r.width      = w;
                    r.ok         = flags[it.ch];
                end
            end
        end
        r.flags = flags;
        pending_results.push_back(r);
    endfunction

    task report_mismatch(string what);
        if (mismatches < 50)
            $display("[%0t] MISMATCH %s", $time, what);
        mismatches++;
    endtask

    task compare_field(string name, logic [WIDTH_W-1:0] got, logic [WIDTH_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                      n_results, name, got, want));
    endtask

    task check_result(pulse_result_t got);
        pulse_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with no transaction outstanding");
            return;
        end
        want = pending_results.pop_front();
        compare_field("measured", WIDTH_W'(got.measured), WIDTH_W'(want.measured));
        compare_field("out_channel", WIDTH_W'(got.ch), WIDTH_W'(want.ch));
        compare_field("pulse_width", got.width, want.width);
        compare_field("pulse_ok", WIDTH_W'(got.ok), WIDTH_W'(want.ok));
        compare_field("all_flags", WIDTH_W'(got.flags), WIDTH_W'(want.flags));
        n_results++;
        if (want.measured)
            n_measured++;
        if (want.ok)
            n_hits++;
    endtask
endclass

module tb_multichannel_pulse_width_window_check;

    localparam int NUM_CH          = 8;
    localparam int CH_PER_GRP      = 4;
    localparam int COUNTS_PER_WRAP = 10000;
    localparam int CAP_MAX         = (1 << CAP_W) - 1;
    localparam int WIN_MAX         = (1 << WIN_W) - 1;
    localparam int PHASE_ITEMS     = 200;
    localparam int NUM_PHASES      = 8;

    typedef pulse_window_scoreboard #(NUM_CH, CH_PER_GRP, COUNTS_PER_WRAP) board_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mpw_in_if  in_ch ();
    mpw_out_if out_ch ();

    board_t sb;
    int     idle_pct;
    int     stall_pct;
    int     hold_left;
    int     n_sent;
    int     n_reg_writes;
    int     n_settings;

    window_setting_t phase_plan [NUM_PHASES] = '{
        WS_RANDOM, WS_ZERO, WS_WIDE, WS_MAX, WS_INVERTED, WS_UPPER_NOISE, WS_DEFAULT, WS_RANDOM
    };

    multichannel_pulse_width_window_check #(
        .NUM_CHANNELS       (NUM_CH),
        .CHANNELS_PER_GROUP (CH_PER_GRP),
        .COUNTS_PER_WRAP    (COUNTS_PER_WRAP)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result receiver: random stalls, plus a counted hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                out_ch.ready <= (int'($urandom_range(99)) >= stall_pct);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        pulse_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.measured = out_ch.measured;
            got.ch       = out_ch.out_channel;
            got.width    = out_ch.pulse_width;
            got.ok       = out_ch.pulse_ok;
            got.flags    = out_ch.all_flags;
            sb.check_result(got);
        end
    end

    function automatic capture_event_t make_tick(logic grp);
        capture_event_t it;
        it.op  = OP_TICK;
        it.grp = grp;
        it.ch  = CHAN_W'($urandom_range(NUM_CH - 1));
        it.lvl = 1'($urandom_range(1));
        it.cap = CAP_W'($urandom_range(CAP_MAX));
        return it;
    endfunction

    function automatic capture_event_t make_edge(int ch, logic lvl, int cap);
        capture_event_t it;
        it.op  = OP_EDGE;
        it.grp = 1'($urandom_range(1));
        it.ch  = CHAN_W'(ch);
        it.lvl = lvl;
        it.cap = CAP_W'(cap);
        return it;
    endfunction

    // Offer one transaction, wait for acceptance, then maybe go idle
    task automatic issue(input capture_event_t it);
        int gap;
        @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= it.op;
        in_ch.group   <= it.grp;
        in_ch.channel <= it.ch;
        in_ch.level   <= it.lvl;
        in_ch.capture <= it.cap;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_event(it);
        n_sent++;
        gap = 0;
        while (int'($urandom_range(99)) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop offering and wait until every result is back
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write, then read back the same register
    task automatic write_window(int idx, logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_window(idx, data[WIN_W-1:0]);
        n_reg_writes++;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        if (rd !== APB_DATA_W'(data[WIN_W-1:0]))
            sb.report_mismatch($sformatf("readback reg %0d: got 0x%0h, want 0x%0h",
                                         idx, rd, data[WIN_W-1:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Program all four windows for one setting
    task automatic apply_windows(window_setting_t ws);
        int lo;
        int hi;
        logic [APB_DATA_W-1:0] junk;
        for (int r = WIN_A_LOW; r <= WIN_D_LOW; r += 2)
        begin
            lo   = int'($urandom_range(20000));
            hi   = lo + int'($urandom_range(1, 6000));
            junk = '0;
            case (ws)
                WS_ZERO:
                begin
                    lo = 0;
                    hi = 0;
                end
                WS_MAX:
                begin
                    lo = WIN_MAX;
                    hi = WIN_MAX;
                end
                WS_WIDE:
                    if (r == WIN_A_LOW)
                    begin
                        lo = 0;
                        hi = WIN_MAX;
                    end
                WS_INVERTED:
                begin
                    hi = int'($urandom_range(20000));
                    lo = hi + int'($urandom_range(3000));
                end
                WS_UPPER_NOISE:
                    // upper pwdata bits must be dropped by the register
                    junk = {APB_DATA_W'($urandom) >> WIN_W} << WIN_W;
                WS_DEFAULT:
                begin
                    lo = int'(WIN_RESET[r]);
                    hi = int'(WIN_RESET[r+1]);
                end
                default: ;
            endcase
            write_window(r, junk | APB_DATA_W'(lo));
            write_window(r + 1, junk | APB_DATA_W'(hi));
        end
        n_settings++;
    endtask

    // Rising edge, some wraps, falling edge; falling capture often aimed at a bound
    task automatic run_pulse(int ticks);
        int c;
        int st;
        int fc;
        int tgt;
        int sel;
        c  = int'($urandom_range(NUM_CH - 1));
        st = int'($urandom_range(CAP_MAX));
        if (ticks < 0)
            ticks = ($urandom_range(9) == 0) ? int'($urandom_range(4, 12))
                                              : int'($urandom_range(3));
        issue(make_edge(c, LEVEL_RISE, st));
        for (int k = 0; k < ticks; k++)
        begin
            if ($urandom_range(9) < 2)
                issue(make_edge((c + 1 + int'($urandom_range(NUM_CH - 2))) % NUM_CH,
                                1'($urandom_range(1)), int'($urandom_range(CAP_MAX))));
            issue(make_tick(1'(c / CH_PER_GRP)));
        end
        fc = int'($urandom_range(CAP_MAX));
        if ($urandom_range(3) != 0)
        begin
            sel = int'($urandom_range(REG_COUNT - 1));
            tgt = int'(sb.win_bounds[sel]) + int'($urandom_range(2)) - 1;
            tgt = tgt + st - (ticks % 256) * COUNTS_PER_WRAP;
            if (tgt >= 0 && tgt <= CAP_MAX)
                fc = tgt;
        end
        issue(make_edge(c, LEVEL_FALL, fc));
    endtask

    task automatic random_step();
        int r;
        r = int'($urandom_range(99));
        if (r < 60)
            run_pulse(-1);
        else if (r < 80)
            issue(make_tick(1'($urandom_range(1))));
        else
            issue(make_edge(int'($urandom_range(NUM_CH - 1)), 1'($urandom_range(1)),
                            int'($urandom_range(CAP_MAX))));
    endtask

    // Main sequence
    initial
    begin
        int target;
        flow_mode_t mode;
        sb            = new();
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.opcode  = OP_TICK;
        in_ch.group   = 1'b0;
        in_ch.channel = '0;
        in_ch.level   = LEVEL_FALL;
        in_ch.capture = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_left     = 0;
        n_sent        = 0;
        n_reg_writes  = 0;
        n_settings    = 1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed cases on the reset windows
        issue(make_edge(0, LEVEL_FALL, 500));      // fall with no rise: width from zero state
        issue(make_edge(1, LEVEL_RISE, 100));
        issue(make_edge(1, LEVEL_FALL, 900));      // width on upper bound: no match
        issue(make_edge(1, LEVEL_FALL, 400));      // width on lower bound: no match
        issue(make_edge(1, LEVEL_FALL, 401));      // just inside first window
        issue(make_edge(2, LEVEL_RISE, 9000));
        issue(make_tick(1'b0));
        issue(make_edge(2, LEVEL_FALL, 500));      // one wrap, second window
        issue(make_edge(2, LEVEL_FALL, 0));        // wrap count survives a fall
        issue(make_edge(3, LEVEL_RISE, CAP_MAX));  // capture beyond counter period
        issue(make_edge(3, LEVEL_FALL, 0));        // negative width wraps mod 2^32
        issue(make_edge(4, LEVEL_RISE, 0));
        issue(make_tick(1'b1));
        issue(make_tick(1'b1));
        issue(make_edge(4, LEVEL_FALL, CAP_MAX));
        issue(make_edge(5, LEVEL_RISE, 10000));
        issue(make_edge(5, LEVEL_FALL, 14400));    // third window
        issue(make_edge(6, LEVEL_RISE, 0));
        issue(make_edge(6, LEVEL_FALL, 2599));     // fourth window, top edge
        issue(make_edge(7, LEVEL_RISE, 5000));
        issue(make_tick(1'b0));                    // other group: channel 7 untouched
        issue(make_edge(7, LEVEL_FALL, 6799));
        issue(make_edge(0, LEVEL_RISE, 0));
        issue(make_edge(0, LEVEL_FALL, 0));        // zero width clears the flag

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            apply_windows(phase_plan[ph]);
            mode      = flow_mode_t'(ph % 4);
            idle_pct  = (mode == FLOW_SENDER_IDLE) ? 87 : (mode == FLOW_BOTH) ? 11 : 0;
            stall_pct = (mode == FLOW_RECEIVER_STALL) ? 87 : (mode == FLOW_BOTH) ? 11 : 0;
            if (ph == 4)
            begin
                // receiver holds off while back-to-back pulses fill the pipe
                hold_left = 150;
                repeat (10) run_pulse(0);
            end
            if (ph == 2)
                run_pulse(257);  // wrap counter rolls over
            target = n_sent + PHASE_ITEMS;
            while (n_sent < target)
                random_step();
        end

        drain();
        repeat (10) @(posedge clk);
        $display("Run covered %0d events, %0d results, %0d widths measured, %0d in a window",
                 n_sent, sb.n_results, sb.n_measured, sb.n_hits);
        $display("over %0d window settings (%0d register writes), %0d mismatches",
                 n_settings, n_reg_writes, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
